[src/isfd_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the IMU serial frame decoder.
// No dependencies.
package isfd_pkg;

    localparam logic [7:0] HEADER_BYTE = 8'h55;
    localparam logic [7:0] TYPE_ACCEL  = 8'h51;
    localparam logic [7:0] TYPE_GYRO   = 8'h52;
    localparam logic [7:0] TYPE_ANGLE  = 8'h53;

    localparam logic [1:0] KIND_ACCEL = 2'd0;
    localparam logic [1:0] KIND_GYRO  = 2'd1;
    localparam logic [1:0] KIND_ANGLE = 2'd2;

    localparam logic [1:0] CFG_ACCEL_FS = 2'd0;
    localparam logic [1:0] CFG_GYRO_FS  = 2'd1;
    localparam logic [1:0] CFG_ANGLE_FS = 2'd2;

    localparam int FS_W  = 11;
    localparam int VAL_W = 27;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] w0;
        logic signed [15:0] w1;
        logic signed [15:0] w2;
        logic signed [15:0] w3;
    } frame_t;

    typedef struct packed {
        logic [FS_W-1:0] accel_fs;
        logic [FS_W-1:0] gyro_fs;
        logic [FS_W-1:0] angle_fs;
    } scale_cfg_t;

endpackage

[src/isfd_frame_assembler.sv]
`timescale 1ns / 1ps
// Byte-level frame parser: header hunt, type/payload capture, frame register.
// Depends on isfd_pkg.
module isfd_frame_assembler import isfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       frame_valid,
    input  logic       frame_ready,
    output frame_t     frame
);

    localparam logic [3:0] PHASE_HUNT  = 4'd0;
    localparam logic [3:0] PHASE_TYPE  = 4'd1;
    localparam logic [3:0] PHASE_DATA0 = 4'd2;
    localparam logic [3:0] PHASE_DATA7 = 4'd9;
    localparam logic [3:0] PHASE_CHECK = 4'd10;

    logic [3:0] phase_reg, phase_next;
    logic [7:0] type_reg;
    logic [7:0] payload_reg [8];
    logic       frame_valid_reg, frame_valid_next;
    frame_t     frame_reg, frame_next;
    logic       accept;
    logic [3:0] data_offset;

    assign in_ready    = !frame_valid_reg || frame_ready;
    assign accept      = in_valid && in_ready;
    assign data_offset = phase_reg - PHASE_DATA0;

    always_comb
    begin
        phase_next       = phase_reg;
        frame_valid_next = frame_valid_reg && !frame_ready;
        frame_next       = frame_reg;
        frame_next.w0    = {payload_reg[1], payload_reg[0]};
        frame_next.w1    = {payload_reg[3], payload_reg[2]};
        frame_next.w2    = {payload_reg[5], payload_reg[4]};
        frame_next.w3    = {payload_reg[7], payload_reg[6]};
        frame_next.kind  = KIND_ACCEL;
        if (accept)
        begin
            case (phase_reg) inside
                PHASE_TYPE:
                begin
                    phase_next = PHASE_DATA0;
                end
                [PHASE_DATA0:PHASE_DATA7]:
                begin
                    phase_next = phase_reg + 4'd1;
                end
                PHASE_CHECK:
                begin
                    phase_next = PHASE_HUNT;
                    case (type_reg)
                        TYPE_ACCEL:
                        begin
                            frame_valid_next = 1'b1;
                            frame_next.kind  = KIND_ACCEL;
                        end
                        TYPE_GYRO:
                        begin
                            frame_valid_next = 1'b1;
                            frame_next.kind  = KIND_GYRO;
                        end
                        TYPE_ANGLE:
                        begin
                            frame_valid_next = 1'b1;
                            frame_next.kind  = KIND_ANGLE;
                        end
                        default:
                        begin
                            frame_valid_next = frame_valid_reg && !frame_ready;
                        end
                    endcase
                end
                default:
                begin
                    phase_next = (rx_byte == HEADER_BYTE) ? PHASE_TYPE : PHASE_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PHASE_HUNT;
            frame_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            frame_valid_reg <= frame_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && phase_reg == PHASE_TYPE)
        begin
            type_reg <= rx_byte;
        end
        if (accept && phase_reg >= PHASE_DATA0 && phase_reg <= PHASE_DATA7)
        begin
            payload_reg[data_offset[2:0]] <= rx_byte;
        end
        if (accept && phase_reg == PHASE_CHECK)
        begin
            frame_reg <= frame_next;
        end
    end

    assign frame_valid = frame_valid_reg;
    assign frame       = frame_reg;

    a_frame_from_checksum: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(frame_valid_reg) |-> $past(accept && phase_reg == PHASE_CHECK))
        else $error("frame produced outside checksum byte");

    a_type_to_data: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && phase_reg == PHASE_TYPE) |=> phase_reg == PHASE_DATA0)
        else $error("type byte did not start payload capture");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (frame_valid_reg && !frame_ready))
        else $error("input stalled with free frame slot");

endmodule

[src/isfd_scaler.sv]
`timescale 1ns / 1ps
// Full-scale multiply, axis mapping and result register.
// Depends on isfd_pkg.
module isfd_scaler import isfd_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    frame_valid,
    output logic                    frame_ready,
    input  frame_t                  frame,
    input  scale_cfg_t              scale_cfg,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [1:0]              kind,
    output logic signed [VAL_W-1:0] first_value,
    output logic signed [VAL_W-1:0] second_value,
    output logic signed [VAL_W-1:0] third_value,
    output logic signed [15:0]      temperature
);

    logic [FS_W-1:0]          fs;
    logic signed [FS_W:0]     fs_s;
    logic signed [VAL_W:0]    p0, p1, p2, neg_p1;
    logic                     out_valid_reg, out_valid_next;
    logic [1:0]               kind_reg;
    logic signed [VAL_W-1:0]  first_reg, first_next;
    logic signed [VAL_W-1:0]  second_reg, second_next;
    logic signed [VAL_W-1:0]  third_reg, third_next;
    logic signed [15:0]       temp_reg, temp_next;
    logic                     load;

    assign frame_ready = !out_valid_reg || out_ready;
    assign load        = frame_valid && frame_ready;

    always_comb
    begin
        case (frame.kind)
            KIND_ACCEL: fs = scale_cfg.accel_fs;
            KIND_GYRO:  fs = scale_cfg.gyro_fs;
            default:    fs = scale_cfg.angle_fs;
        endcase
    end

    assign fs_s   = signed'({1'b0, fs});
    assign p0     = VAL_W'(frame.w0) * fs_s;
    assign p1     = VAL_W'(frame.w1) * fs_s;
    assign p2     = VAL_W'(frame.w2) * fs_s;
    assign neg_p1 = -p1;

    always_comb
    begin
        third_next = p2[VAL_W-1:0];
        if (frame.kind == KIND_ANGLE)
        begin
            first_next  = neg_p1[VAL_W-1:0];
            second_next = p0[VAL_W-1:0];
        end
        else
        begin
            first_next  = p0[VAL_W-1:0];
            second_next = p1[VAL_W-1:0];
        end
        temp_next = (frame.kind == KIND_ACCEL) ? frame.w3 : 16'sd0;
    end

    assign out_valid_next = load || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg   <= frame.kind;
            first_reg  <= first_next;
            second_reg <= second_next;
            third_reg  <= third_next;
            temp_reg   <= temp_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign first_value  = first_reg;
    assign second_value = second_reg;
    assign third_value  = third_reg;
    assign temperature  = temp_reg;

    a_temp_only_accel: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg != KIND_ACCEL) |-> temp_reg == 16'sd0)
        else $error("temperature nonzero on non-accel result");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (kind_reg == KIND_ACCEL || kind_reg == KIND_GYRO ||
                           kind_reg == KIND_ANGLE))
        else $error("illegal result kind");

    a_load_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> out_valid_reg)
        else $error("loaded frame lost");

endmodule

[src/imu_serial_frame_decoder_core.sv]
`timescale 1ns / 1ps
// IMU serial frame decoder top: config registers, frame parser, scaler.
// Checksum byte loads the frame register, then the scaler's result register.
// One byte per cycle unless stalled; parser and scaler each hold one frame.
// Reset: parser hunts for header, scales return to 16 / 2000 / 180.
// Depends on isfd_pkg, isfd_frame_assembler, isfd_scaler.
module imu_serial_frame_decoder_core import isfd_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [7:0]              rx_byte,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [1:0]              cfg_index,
    input  logic [FS_W-1:0]         cfg_data,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [1:0]              kind,
    output logic signed [VAL_W-1:0] first_value,
    output logic signed [VAL_W-1:0] second_value,
    output logic signed [VAL_W-1:0] third_value,
    output logic signed [15:0]      temperature
);

    scale_cfg_t scale_reg;
    logic       frame_valid;
    logic       frame_ready;
    frame_t     frame;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg.accel_fs <= FS_W'(16);
            scale_reg.gyro_fs  <= FS_W'(2000);
            scale_reg.angle_fs <= FS_W'(180);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ACCEL_FS: scale_reg.accel_fs <= cfg_data;
                CFG_GYRO_FS:  scale_reg.gyro_fs  <= cfg_data;
                CFG_ANGLE_FS: scale_reg.angle_fs <= cfg_data;
                default:      scale_reg <= scale_reg;
            endcase
        end
    end

    isfd_frame_assembler u_assembler (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rx_byte     (rx_byte),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame       (frame)
    );

    isfd_scaler u_scaler (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_valid  (frame_valid),
        .frame_ready  (frame_ready),
        .frame        (frame),
        .scale_cfg    (scale_reg),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .first_value  (first_value),
        .second_value (second_value),
        .third_value  (third_value),
        .temperature  (temperature)
    );

endmodule

[test/tb_imu_serial_frame_decoder_core.sv]
`timescale 1ns / 1ps
// Self-checking testbench for imu_serial_frame_decoder_core: byte and config drivers,
// a randomly stalled result sink and a frame-level scoreboard that predicts each result.
// Depends on isfd_pkg and the decoder RTL.
import isfd_pkg::*;

typedef struct packed {
    logic [1:0]               kind;
    logic signed [VAL_W-1:0]  first_value;
    logic signed [VAL_W-1:0]  second_value;
    logic signed [VAL_W-1:0]  third_value;
    logic signed [15:0]       temperature;
} imu_result_t;

class imu_frame_scoreboard;
    localparam logic [3:0] PH_HUNT  = 4'd0;
    localparam logic [3:0] PH_TYPE  = 4'd1;
    localparam logic [3:0] PH_DATA0 = 4'd2;
    localparam logic [3:0] PH_CHECK = 4'd10;

    logic [3:0]      phase;
    logic [7:0]      type_byte;
    logic [7:0]      payload [8];
    logic [FS_W-1:0] accel_fs;
    logic [FS_W-1:0] gyro_fs;
    logic [FS_W-1:0] angle_fs;
    imu_result_t     result_q [$];
    int              mismatches;

    function new();
        phase = PH_HUNT;
        type_byte = 8'h00;
        foreach (payload[i]) payload[i] = 8'h00;
        accel_fs = 11'd16;
        gyro_fs = 11'd2000;
        angle_fs = 11'd180;
        mismatches = 0;
    endfunction

    function void set_scale(logic [1:0] idx, logic [FS_W-1:0] val);
        case (idx)
            CFG_ACCEL_FS: accel_fs = val;
            CFG_GYRO_FS:  gyro_fs = val;
            CFG_ANGLE_FS: angle_fs = val;
            default: ;
        endcase
    endfunction

    function logic signed [VAL_W-1:0] scaled(logic signed [15:0] w, logic [FS_W-1:0] fs,
                                             bit negate);
        logic signed [31:0] ws;
        logic signed [31:0] fss;
        logic signed [31:0] p;
        ws = w;
        fss = {21'b0, fs};
        p = ws * fss;
        if (negate)
            p = -p;
        return p[VAL_W-1:0];
    endfunction

    function logic signed [15:0] word_at(int k);
        return {payload[2 * k + 1], payload[2 * k]};
    endfunction

    function void note_byte(logic [7:0] b);
        imu_result_t r;
        if (phase == PH_TYPE) begin
            type_byte = b;
            phase = PH_DATA0;
        end else if (phase >= PH_DATA0 && phase < PH_CHECK) begin
            payload[phase - PH_DATA0] = b;
            phase = phase + 4'd1;
        end else if (phase != PH_CHECK) begin
            phase = (b == HEADER_BYTE) ? PH_TYPE : PH_HUNT;
        end else begin
            // checksum byte closes the frame, value ignored
            phase = PH_HUNT;
            r.temperature = 16'sd0;
            if (type_byte == TYPE_ACCEL) begin
                r.kind = KIND_ACCEL;
                r.first_value = scaled(word_at(0), accel_fs, 1'b0);
                r.second_value = scaled(word_at(1), accel_fs, 1'b0);
                r.third_value = scaled(word_at(2), accel_fs, 1'b0);
                r.temperature = word_at(3);
                result_q.push_back(r);
            end else if (type_byte == TYPE_GYRO) begin
                r.kind = KIND_GYRO;
                r.first_value = scaled(word_at(0), gyro_fs, 1'b0);
                r.second_value = scaled(word_at(1), gyro_fs, 1'b0);
                r.third_value = scaled(word_at(2), gyro_fs, 1'b0);
                result_q.push_back(r);
            end else if (type_byte == TYPE_ANGLE) begin
                r.kind = KIND_ANGLE;
                r.first_value = scaled(word_at(1), angle_fs, 1'b1);
                r.second_value = scaled(word_at(0), angle_fs, 1'b0);
                r.third_value = scaled(word_at(2), angle_fs, 1'b0);
                result_q.push_back(r);
            end
        end
    endfunction

    function void check_result(imu_result_t got);
        imu_result_t exp_r;
        if (result_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] unexpected result kind=%0d %0d %0d %0d temp=%0d", $time,
                         got.kind, got.first_value, got.second_value, got.third_value,
                         got.temperature);
            return;
        end
        exp_r = result_q.pop_front();
        if (got.kind !== exp_r.kind || got.first_value !== exp_r.first_value ||
            got.second_value !== exp_r.second_value ||
            got.third_value !== exp_r.third_value || got.temperature !== exp_r.temperature)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] result mismatch: exp kind=%0d %0d %0d %0d temp=%0d, got kind=%0d %0d %0d %0d temp=%0d",
                         $time, exp_r.kind, exp_r.first_value, exp_r.second_value,
                         exp_r.third_value, exp_r.temperature, got.kind, got.first_value,
                         got.second_value, got.third_value, got.temperature);
        end
    endfunction

    function int pending();
        return result_q.size();
    endfunction
endclass

module tb_imu_serial_frame_decoder_core;
    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LIMIT = 2000;
    localparam int BYTES_PER_PHASE = 360;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic [7:0]              rx_byte = 8'h00;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [1:0]              cfg_index = CFG_ACCEL_FS;
    logic [FS_W-1:0]         cfg_data = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [1:0]              kind;
    logic signed [VAL_W-1:0] first_value;
    logic signed [VAL_W-1:0] second_value;
    logic signed [VAL_W-1:0] third_value;
    logic signed [15:0]      temperature;

    imu_frame_scoreboard sb = new();
    int burst_left = 0;
    int idle_cycles = 0;
    int sink_cycle = 0;
    int sink_mode = 0;

    imu_serial_frame_decoder_core uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .rx_byte(rx_byte),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .kind(kind),
        .first_value(first_value),
        .second_value(second_value),
        .third_value(third_value),
        .temperature(temperature)
    );

    always #5 clk = ~clk;

    // result sink: ready pattern in one of four random modes, re-picked from sink_cycle
    always @(negedge clk)
    begin
        if (sink_cycle % 64 == 0)
            sink_mode = $urandom_range(0, 3);
        sink_cycle++;
        case (sink_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 3) != 0);
            2: out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= (sink_cycle % 8 == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (out_valid && out_ready)
            sb.check_result({kind, first_value, second_value, third_value, temperature});
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 16);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        @(negedge clk);
        in_valid <= 1'b1;
        rx_byte <= b;
        do @(posedge clk); while (!in_ready);
        sb.note_byte(b);
        burst_left--;
    endtask

    task automatic send_frame(input logic [7:0] frame_type, input logic [15:0] w0,
                              input logic [15:0] w1, input logic [15:0] w2,
                              input logic [15:0] w3, input logic [7:0] chk);
        send_byte(HEADER_BYTE);
        send_byte(frame_type);
        send_byte(w0[7:0]);
        send_byte(w0[15:8]);
        send_byte(w1[7:0]);
        send_byte(w1[15:8]);
        send_byte(w2[7:0]);
        send_byte(w2[15:8]);
        send_byte(w3[7:0]);
        send_byte(w3[15:8]);
        send_byte(chk);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        burst_left = 0;
    endtask

    task automatic write_scale(input logic [1:0] idx, input logic [FS_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        sb.set_scale(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_scales(input logic [FS_W-1:0] a, input logic [FS_W-1:0] g,
                                input logic [FS_W-1:0] n);
        write_scale(CFG_ACCEL_FS, a);
        write_scale(CFG_GYRO_FS, g);
        write_scale(CFG_ANGLE_FS, n);
    endtask

    function automatic logic [7:0] pick_type();
        case ($urandom_range(0, 9))
            0, 1, 2: return TYPE_ACCEL;
            3, 4, 5: return TYPE_GYRO;
            6, 7, 8: return TYPE_ANGLE;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic run_random(input int n_bytes);
        int sent = 0;
        while (sent < n_bytes)
        begin
            // noise while hunting; a stray header here breaks the frame alignment
            if ($urandom_range(0, 5) == 0)
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
            send_frame(pick_type(), pick_word(), pick_word(), pick_word(), pick_word(),
                       8'($urandom_range(0, 255)));
            sent += 11;
        end
    endtask

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // directed: reset scales, word extremes, header as data, unknown type
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(TYPE_ACCEL, 16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 8'hAA);
        send_frame(TYPE_GYRO, 16'h5555, 16'h0001, 16'h7FFF, 16'h8000, HEADER_BYTE);
        send_frame(TYPE_ANGLE, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h3412, 8'h00);
        send_frame(8'h50, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 8'hFF);
        run_random(BYTES_PER_PHASE);

        wait_drained();
        write_scales(11'd0, 11'd0, 11'd0);
        write_scale(CFG_UNUSED, 11'h7FF);
        run_random(BYTES_PER_PHASE);

        wait_drained();
        write_scales(11'h7FF, 11'h7FF, 11'h7FF);
        send_frame(TYPE_ANGLE, 16'h7FFF, 16'h8000, 16'h8000, 16'h0000, 8'h55);
        run_random(BYTES_PER_PHASE);

        wait_drained();
        write_scales(11'd1, 11'd2000, 11'd1);
        run_random(BYTES_PER_PHASE);

        wait_drained();
        write_scales(11'($urandom_range(1, 2000)), 11'($urandom_range(1, 2000)),
                     11'($urandom_range(1, 2000)));
        run_random(BYTES_PER_PHASE);

        wait_drained();
        if (sb.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

[imu_serial_frame_decoder_core.f]
src/isfd_pkg.sv
src/isfd_frame_assembler.sv
src/isfd_scaler.sv
src/imu_serial_frame_decoder_core.sv
test/tb_imu_serial_frame_decoder_core.sv
